>>> sv/button_to_motor_frames_defines.svh
// Assertion macros for the button_to_motor_frames block.
`ifndef BUTTON_TO_MOTOR_FRAMES_DEFINES_SVH
`define BUTTON_TO_MOTOR_FRAMES_DEFINES_SVH

`ifndef SYNTH
// a in this cycle implies b in the same cycle
`define BTM_ASSERT_IMPL(name, a, b) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("btm assertion failed");
// a in this cycle implies b in the next cycle
`define BTM_ASSERT_NEXT(name, a, b) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("btm assertion failed");
`else
`define BTM_ASSERT_IMPL(name, a, b)
`define BTM_ASSERT_NEXT(name, a, b)
`endif

`endif

>>> sv/btm_pkg.sv
// Shared types, codes and the drive pattern decode for the button to motor frame block.
`default_nettype none
package btm_pkg;

  localparam int ADDR_W = 5;

  // driver addresses
  localparam logic [7:0] ADDR_RIGHT = 8'd132;
  localparam logic [7:0] ADDR_LEFT  = 8'd133;
  localparam logic [7:0] ADDR_BELT  = 8'd134;

  // driver commands
  localparam logic [2:0] CMD_M1_FWD = 3'd0;
  localparam logic [2:0] CMD_M1_REV = 3'd1;
  localparam logic [2:0] CMD_M2_FWD = 3'd4;
  localparam logic [2:0] CMD_M2_REV = 3'd5;

  // button codes
  localparam logic [7:0] BTN_FORWARD  = 8'h01;
  localparam logic [7:0] BTN_DIAG_R   = 8'h05;
  localparam logic [7:0] BTN_DIAG_L   = 8'h09;
  localparam logic [7:0] BTN_BACKWARD = 8'h02;
  localparam logic [7:0] BTN_SPIN_A   = 8'h04;
  localparam logic [7:0] BTN_SPIN_B   = 8'h08;
  localparam logic [7:0] BTN_CURVE_A  = 8'h40;
  localparam logic [7:0] BTN_CURVE_B  = 8'h80;
  localparam logic [7:0] BTN_BELT_REV = 8'h10;
  localparam logic [7:0] BTN_BELT_FWD = 8'h20;
  localparam logic [7:0] BTN_LAMP_ON  = 8'h11;
  localparam logic [7:0] BTN_LAMP_OFF = 8'h22;

  // register indexes
  localparam logic [2:0] REG_RAMP_STEP      = 3'd0;
  localparam logic [2:0] REG_STRAIGHT_LIMIT = 3'd1;
  localparam logic [2:0] REG_TURN_LIMIT     = 3'd2;
  localparam logic [2:0] REG_CURVE_LIMIT    = 3'd3;
  localparam logic [2:0] REG_CONVEYOR_SPEED = 3'd4;
  localparam logic [2:0] REG_PRESS_OFFSET   = 3'd5;
  localparam logic [2:0] REG_COAST_OFFSET   = 3'd6;

  // register reset values
  localparam logic [3:0] RST_RAMP_STEP      = 4'd3;
  localparam logic [6:0] RST_STRAIGHT_LIMIT = 7'd127;
  localparam logic [6:0] RST_TURN_LIMIT     = 7'd35;
  localparam logic [6:0] RST_CURVE_LIMIT    = 7'd102;
  localparam logic [6:0] RST_CONVEYOR_SPEED = 7'd127;
  localparam logic [6:0] RST_PRESS_OFFSET   = 7'd25;
  localparam logic [6:0] RST_COAST_OFFSET   = 7'd20;

  typedef struct packed {
    logic [3:0] ramp_step;
    logic [6:0] straight_limit;
    logic [6:0] turn_limit;
    logic [6:0] curve_limit;
    logic [6:0] conveyor_speed;
    logic [6:0] press_offset;
    logic [6:0] coast_offset;
  } cfg_t;

  // one request's worth of frames: commands and values for all five
  typedef struct packed {
    logic [2:0] rc1;
    logic [2:0] rc2;
    logic [6:0] rv;
    logic [2:0] lc1;
    logic [2:0] lc2;
    logic [6:0] lv;
    logic [2:0] bc;
    logic [6:0] bv;
    logic       lamp;
  } item_t;

  typedef enum logic [2:0] {
    FR_RIGHT_M1 = 3'd0,
    FR_RIGHT_M2 = 3'd1,
    FR_LEFT_M1  = 3'd2,
    FR_LEFT_M2  = 3'd3,
    FR_BELT     = 3'd4
  } frame_t;

  // s: ramped speed, sr: speed less the diagonal offset (floored)
  function automatic item_t drive_pattern(input logic [7:0] code, input logic [6:0] s,
                                          input logic [6:0] sr);
    item_t it;
    it      = '0;
    it.rc1  = CMD_M1_FWD;
    it.rc2  = CMD_M2_FWD;
    it.lc1  = CMD_M1_FWD;
    it.lc2  = CMD_M2_FWD;
    it.bc   = CMD_M1_FWD;
    unique case (code)
      BTN_FORWARD: begin
        it.rc2 = CMD_M2_REV; it.rv = s;
        it.lc1 = CMD_M1_REV; it.lv = s;
      end
      BTN_DIAG_R: begin
        it.rc2 = CMD_M2_REV; it.rv = sr;
        it.lc1 = CMD_M1_REV; it.lv = s;
      end
      BTN_DIAG_L: begin
        it.rc2 = CMD_M2_REV; it.rv = s;
        it.lc1 = CMD_M1_REV; it.lv = sr;
      end
      BTN_BACKWARD: begin
        it.rc1 = CMD_M1_REV; it.rv = s;
        it.lc2 = CMD_M2_REV; it.lv = s;
      end
      BTN_SPIN_A: begin
        it.rc1 = CMD_M1_REV; it.rv = s;
        it.lc1 = CMD_M1_REV; it.lv = s;
      end
      BTN_SPIN_B: begin
        it.rc2 = CMD_M2_REV; it.rv = s;
        it.lc2 = CMD_M2_REV; it.lv = s;
      end
      BTN_CURVE_A: begin
        it.lc1 = CMD_M1_REV; it.lv = s;
      end
      BTN_CURVE_B: begin
        it.rc2 = CMD_M2_REV; it.rv = s;
      end
      default: begin
      end
    endcase
    return it;
  endfunction

endpackage
`default_nettype wire

>>> sv/btm_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none
module btm_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [btm_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output btm_pkg::cfg_t                 cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[btm_pkg::ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_step      <= btm_pkg::RST_RAMP_STEP;
      cfg.straight_limit <= btm_pkg::RST_STRAIGHT_LIMIT;
      cfg.turn_limit     <= btm_pkg::RST_TURN_LIMIT;
      cfg.curve_limit    <= btm_pkg::RST_CURVE_LIMIT;
      cfg.conveyor_speed <= btm_pkg::RST_CONVEYOR_SPEED;
      cfg.press_offset   <= btm_pkg::RST_PRESS_OFFSET;
      cfg.coast_offset   <= btm_pkg::RST_COAST_OFFSET;
    end else if (wr) begin
      unique case (idx)
        btm_pkg::REG_RAMP_STEP:      cfg.ramp_step      <= pwdata[3:0];
        btm_pkg::REG_STRAIGHT_LIMIT: cfg.straight_limit <= pwdata[6:0];
        btm_pkg::REG_TURN_LIMIT:     cfg.turn_limit     <= pwdata[6:0];
        btm_pkg::REG_CURVE_LIMIT:    cfg.curve_limit    <= pwdata[6:0];
        btm_pkg::REG_CONVEYOR_SPEED: cfg.conveyor_speed <= pwdata[6:0];
        btm_pkg::REG_PRESS_OFFSET:   cfg.press_offset   <= pwdata[6:0];
        btm_pkg::REG_COAST_OFFSET:   cfg.coast_offset   <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      btm_pkg::REG_RAMP_STEP:      prdata = {28'd0, cfg.ramp_step};
      btm_pkg::REG_STRAIGHT_LIMIT: prdata = {25'd0, cfg.straight_limit};
      btm_pkg::REG_TURN_LIMIT:     prdata = {25'd0, cfg.turn_limit};
      btm_pkg::REG_CURVE_LIMIT:    prdata = {25'd0, cfg.curve_limit};
      btm_pkg::REG_CONVEYOR_SPEED: prdata = {25'd0, cfg.conveyor_speed};
      btm_pkg::REG_PRESS_OFFSET:   prdata = {25'd0, cfg.press_offset};
      btm_pkg::REG_COAST_OFFSET:   prdata = {25'd0, cfg.coast_offset};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/btm_front.sv
// Front end: classifies a button code, updates the ramp state and builds the frame set.
`default_nettype none
module btm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  btm_pkg::cfg_t        cfg,
  input  logic                 accept,
  input  logic [7:0]           button_code,
  output btm_pkg::item_t       item
);

  logic [6:0] ramp_speed;
  logic [7:0] previous_code;
  logic       lamp_bit;

  logic [6:0] ramp_speed_next;
  logic [7:0] previous_code_next;
  logic       lamp_bit_next;

  logic       drive;
  logic       idle;
  logic [6:0] limit;
  logic [7:0] sum;
  logic [6:0] off;
  logic [6:0] sr;
  logic [7:0] pat_code;
  btm_pkg::item_t pat;

  always_comb begin
    drive              = 1'b0;
    idle               = 1'b0;
    limit              = cfg.straight_limit;
    lamp_bit_next      = lamp_bit;
    unique case (button_code)
      btm_pkg::BTN_FORWARD, btm_pkg::BTN_DIAG_R, btm_pkg::BTN_DIAG_L,
      btm_pkg::BTN_BACKWARD: begin
        drive = 1'b1;
        limit = cfg.straight_limit;
      end
      btm_pkg::BTN_SPIN_A, btm_pkg::BTN_SPIN_B: begin
        drive = 1'b1;
        limit = cfg.turn_limit;
      end
      btm_pkg::BTN_CURVE_A, btm_pkg::BTN_CURVE_B: begin
        drive = 1'b1;
        limit = cfg.curve_limit;
      end
      btm_pkg::BTN_BELT_REV, btm_pkg::BTN_BELT_FWD: begin
      end
      btm_pkg::BTN_LAMP_ON:  lamp_bit_next = 1'b1;
      btm_pkg::BTN_LAMP_OFF: lamp_bit_next = 1'b0;
      default:               idle = 1'b1;
    endcase

    sum = {1'b0, ramp_speed} + {4'd0, cfg.ramp_step};
    if (drive) begin
      // saturate: a lower limit pulls a higher speed down
      ramp_speed_next = (sum >= {1'b0, limit}) ? limit : sum[6:0];
    end else if (idle) begin
      ramp_speed_next = (ramp_speed > {3'd0, cfg.ramp_step}) ?
                        ramp_speed - {3'd0, cfg.ramp_step} : 7'd0;
    end else begin
      ramp_speed_next = ramp_speed;
    end

    off      = drive ? cfg.press_offset : cfg.coast_offset;
    sr       = (ramp_speed_next > off) ? ramp_speed_next - off : 7'd0;
    // coasting replays the pattern of the last non-idle code
    pat_code = idle ? previous_code : button_code;
    pat      = btm_pkg::drive_pattern(pat_code, ramp_speed_next, sr);

    previous_code_next = idle ? previous_code : button_code;

    item      = pat;
    item.lamp = lamp_bit;
    unique case (button_code)
      btm_pkg::BTN_BELT_REV: begin
        item.bc = btm_pkg::CMD_M1_REV;
        item.bv = cfg.conveyor_speed;
      end
      btm_pkg::BTN_BELT_FWD: begin
        item.bc = btm_pkg::CMD_M1_FWD;
        item.bv = cfg.conveyor_speed;
      end
      btm_pkg::BTN_LAMP_ON:  item.bc = btm_pkg::CMD_M1_REV;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_speed    <= '0;
      previous_code <= '0;
      lamp_bit      <= 1'b0;
    end else if (accept) begin
      ramp_speed    <= ramp_speed_next;
      previous_code <= previous_code_next;
      lamp_bit      <= lamp_bit_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/btm_queue.sv
// Short request queue between the front end and the frame sequencer.
`default_nettype none
module btm_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  btm_pkg::item_t wr_data,
  input  logic           rd,
  output btm_pkg::item_t rd_data,
  output logic           full,
  output logic           empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  btm_pkg::item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == DEPTH_C);
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/btm_back.sv
// Back end: walks the five frames of the head request into the result register.
`default_nettype none
module btm_back (
  input  logic                clk,
  input  logic                rst,
  input  btm_pkg::item_t      head,
  input  logic                q_empty,
  output logic                q_rd,
  input  logic                pop,
  output logic                empty,
  output btm_pkg::frame_t     frame_idx,
  output logic [7:0]          driver_address,
  output logic [2:0]          motor_command,
  output logic [6:0]          drive_value,
  output logic [6:0]          check_byte,
  output logic                lamp_level,
  output logic                last_frame
);

  logic       out_valid;
  logic       advance;
  logic       load;
  logic [7:0] addr;
  logic [2:0] cmd;
  logic [6:0] val;
  logic [7:0] chk;
  btm_pkg::frame_t frame_idx_next;

  assign empty   = !out_valid;
  assign advance = !out_valid || pop;
  assign load    = advance && !q_empty;
  assign q_rd    = load && (frame_idx == btm_pkg::FR_BELT);

  always_comb begin
    frame_idx_next = frame_idx;
    unique case (frame_idx)
      btm_pkg::FR_RIGHT_M1: begin
        addr = btm_pkg::ADDR_RIGHT; cmd = head.rc1; val = head.rv;
        frame_idx_next = btm_pkg::FR_RIGHT_M2;
      end
      btm_pkg::FR_RIGHT_M2: begin
        addr = btm_pkg::ADDR_RIGHT; cmd = head.rc2; val = head.rv;
        frame_idx_next = btm_pkg::FR_LEFT_M1;
      end
      btm_pkg::FR_LEFT_M1: begin
        addr = btm_pkg::ADDR_LEFT; cmd = head.lc1; val = head.lv;
        frame_idx_next = btm_pkg::FR_LEFT_M2;
      end
      btm_pkg::FR_LEFT_M2: begin
        addr = btm_pkg::ADDR_LEFT; cmd = head.lc2; val = head.lv;
        frame_idx_next = btm_pkg::FR_BELT;
      end
      btm_pkg::FR_BELT: begin
        addr = btm_pkg::ADDR_BELT; cmd = head.bc; val = head.bv;
        frame_idx_next = btm_pkg::FR_RIGHT_M1;
      end
      default: begin
        addr = btm_pkg::ADDR_BELT; cmd = head.bc; val = head.bv;
        frame_idx_next = btm_pkg::FR_RIGHT_M1;
      end
    endcase
    chk = addr + {5'd0, cmd} + {1'b0, val};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      frame_idx <= btm_pkg::FR_RIGHT_M1;
    end else if (advance) begin
      out_valid <= !q_empty;
      if (load) begin
        frame_idx <= frame_idx_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      driver_address <= addr;
      motor_command  <= cmd;
      drive_value    <= val;
      check_byte     <= chk[6:0];
      lamp_level     <= head.lamp;
      last_frame     <= (frame_idx == btm_pkg::FR_BELT);
    end
  end

endmodule
`default_nettype wire

>>> sv/button_to_motor_frames.sv
// Top level of the button code to motor driver frame converter.
// Each accepted button code produces five driver frames (right motor1, right motor2,
// left motor1, left motor2, conveyor), delivered from the result register one per
// cycle while pop is held; the frame sequencer emits one frame per clock unless pop
// is low. A button code is classified and the ramp state updated in the cycle it is
// accepted; it then waits in the queue while its frames are loaded into the result
// register. Up to QUEUE_DEPTH pending requests wait between the two halves, so push
// stays open while frames drain until the queue fills. Configuration
// registers sit at byte address 4*index and should only be written while idle.
`default_nettype none
`include "button_to_motor_frames_defines.svh"
module button_to_motor_frames #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [btm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 button_code,
  output logic                       empty,
  input  logic                       pop,
  output logic [7:0]                 driver_address,
  output logic [2:0]                 motor_command,
  output logic [6:0]                 drive_value,
  output logic [6:0]                 check_byte,
  output logic                       lamp_level,
  output logic                       last_frame
);

  btm_pkg::cfg_t   cfg;
  btm_pkg::item_t  item;
  btm_pkg::item_t  head;
  btm_pkg::frame_t frame_idx;
  logic            accept;
  logic            q_full;
  logic            q_empty;
  logic            q_rd;

  assign full   = q_full;
  assign accept = push && !q_full;

  btm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  btm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .button_code (button_code),
    .item        (item)
  );

  btm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept),
    .wr_data (item),
    .rd      (q_rd),
    .rd_data (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  btm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .q_empty        (q_empty),
    .q_rd           (q_rd),
    .pop            (pop),
    .empty          (empty),
    .frame_idx      (frame_idx),
    .driver_address (driver_address),
    .motor_command  (motor_command),
    .drive_value    (drive_value),
    .check_byte     (check_byte),
    .lamp_level     (lamp_level),
    .last_frame     (last_frame)
  );

  // a request is only mid-sequence while it still sits at the queue head
  `BTM_ASSERT_IMPL(a_mid_seq_has_head, frame_idx != btm_pkg::FR_RIGHT_M1, !q_empty)
  // retiring a request puts its conveyor frame in the result register
  `BTM_ASSERT_NEXT(a_retire_last, q_rd, !empty && last_frame)
  `BTM_ASSERT_IMPL(a_last_is_belt, !empty && last_frame,
                   driver_address == btm_pkg::ADDR_BELT)

endmodule
`default_nettype wire

>>> tb/sv/btm_frame_checker.sv
// Frame checker: tracks config writes and button requests, predicts frames, compares them.
`default_nettype none
module btm_frame_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [btm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  input  logic                       push,
  input  logic                       full,
  input  logic [7:0]                 button_code,
  input  logic                       empty,
  input  logic                       pop,
  input  logic [7:0]                 driver_address,
  input  logic [2:0]                 motor_command,
  input  logic [6:0]                 drive_value,
  input  logic [6:0]                 check_byte,
  input  logic                       lamp_level,
  input  logic                       last_frame,
  output int                         mismatches,
  output int                         frames_waiting,
  output int                         frames_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] addr;
    logic [2:0] cmd;
    logic [6:0] val;
    logic [6:0] sum7;
    logic       lamp;
    logic       last;
  } frame_rec_t;

  btm_pkg::cfg_t cfg;
  logic [7:0]    speed;
  logic [7:0]    prev_code;
  logic          lamp_on;
  frame_rec_t    frames_due[$];

  function automatic logic [7:0] floor_sub(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : 8'd0;
  endfunction

  function automatic void queue_frame(input logic [7:0] addr, input logic [2:0] cmd,
                                      input logic [7:0] val, input logic last);
    frame_rec_t f;
    logic [7:0] total;
    total  = addr + {5'd0, cmd} + {1'b0, val[6:0]};
    f.addr = addr;
    f.cmd  = cmd;
    f.val  = val[6:0];
    f.sum7 = total[6:0];
    f.lamp = lamp_on;
    f.last = last;
    frames_due.push_back(f);
  endfunction

  function automatic void queue_request(input logic [2:0] rc1, input logic [2:0] rc2,
                                        input logic [7:0] rv, input logic [2:0] lc1,
                                        input logic [2:0] lc2, input logic [7:0] lv,
                                        input logic [2:0] bc, input logic [7:0] bv);
    queue_frame(btm_pkg::ADDR_RIGHT, rc1, rv, 1'b0);
    queue_frame(btm_pkg::ADDR_RIGHT, rc2, rv, 1'b0);
    queue_frame(btm_pkg::ADDR_LEFT, lc1, lv, 1'b0);
    queue_frame(btm_pkg::ADDR_LEFT, lc2, lv, 1'b0);
    queue_frame(btm_pkg::ADDR_BELT, bc, bv, 1'b1);
  endfunction

  // motion pattern at speed s; off trims the inner side of a diagonal
  function automatic void queue_motion(input logic [7:0] code, input logic [7:0] s,
                                       input logic [7:0] off);
    case (code)
      btm_pkg::BTN_FORWARD:
        queue_request(btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_REV, s,
                      btm_pkg::CMD_M1_REV, btm_pkg::CMD_M2_FWD, s,
                      btm_pkg::CMD_M1_FWD, 8'd0);
      btm_pkg::BTN_DIAG_R:
        queue_request(btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_REV, floor_sub(s, off),
                      btm_pkg::CMD_M1_REV, btm_pkg::CMD_M2_FWD, s,
                      btm_pkg::CMD_M1_FWD, 8'd0);
      btm_pkg::BTN_DIAG_L:
        queue_request(btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_REV, s,
                      btm_pkg::CMD_M1_REV, btm_pkg::CMD_M2_FWD, floor_sub(s, off),
                      btm_pkg::CMD_M1_FWD, 8'd0);
      btm_pkg::BTN_BACKWARD:
        queue_request(btm_pkg::CMD_M1_REV, btm_pkg::CMD_M2_FWD, s,
                      btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_REV, s,
                      btm_pkg::CMD_M1_FWD, 8'd0);
      btm_pkg::BTN_SPIN_A:
        queue_request(btm_pkg::CMD_M1_REV, btm_pkg::CMD_M2_FWD, s,
                      btm_pkg::CMD_M1_REV, btm_pkg::CMD_M2_FWD, s,
                      btm_pkg::CMD_M1_FWD, 8'd0);
      btm_pkg::BTN_SPIN_B:
        queue_request(btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_REV, s,
                      btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_REV, s,
                      btm_pkg::CMD_M1_FWD, 8'd0);
      btm_pkg::BTN_CURVE_A:
        queue_request(btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_FWD, 8'd0,
                      btm_pkg::CMD_M1_REV, btm_pkg::CMD_M2_FWD, s,
                      btm_pkg::CMD_M1_FWD, 8'd0);
      btm_pkg::BTN_CURVE_B:
        queue_request(btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_REV, s,
                      btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_FWD, 8'd0,
                      btm_pkg::CMD_M1_FWD, 8'd0);
      default:
        queue_request(btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_FWD, 8'd0,
                      btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_FWD, 8'd0,
                      btm_pkg::CMD_M1_FWD, 8'd0);
    endcase
  endfunction

  function automatic void frames_for_button(input logic [7:0] code);
    logic [8:0] sum;
    logic [6:0] ceiling;
    logic       moving;
    moving  = 1'b1;
    ceiling = 7'd0;
    case (code)
      btm_pkg::BTN_FORWARD, btm_pkg::BTN_DIAG_R, btm_pkg::BTN_DIAG_L,
      btm_pkg::BTN_BACKWARD:                        ceiling = cfg.straight_limit;
      btm_pkg::BTN_SPIN_A, btm_pkg::BTN_SPIN_B:     ceiling = cfg.turn_limit;
      btm_pkg::BTN_CURVE_A, btm_pkg::BTN_CURVE_B:   ceiling = cfg.curve_limit;
      default:                                      moving = 1'b0;
    endcase
    if (moving) begin
      sum = {1'b0, speed} + {5'd0, cfg.ramp_step};
      speed = (sum >= {2'b00, ceiling}) ? {1'b0, ceiling} : sum[7:0];
      queue_motion(code, speed, {1'b0, cfg.press_offset});
      prev_code = code;
    end else begin
      case (code)
        btm_pkg::BTN_BELT_REV: begin
          queue_request(btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_FWD, 8'd0,
                        btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_FWD, 8'd0,
                        btm_pkg::CMD_M1_REV, {1'b0, cfg.conveyor_speed});
          prev_code = code;
        end
        btm_pkg::BTN_BELT_FWD: begin
          queue_request(btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_FWD, 8'd0,
                        btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_FWD, 8'd0,
                        btm_pkg::CMD_M1_FWD, {1'b0, cfg.conveyor_speed});
          prev_code = code;
        end
        btm_pkg::BTN_LAMP_ON: begin
          // frames carry the old lamp level, the new one shows from the next request
          queue_request(btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_FWD, 8'd0,
                        btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_FWD, 8'd0,
                        btm_pkg::CMD_M1_REV, 8'd0);
          lamp_on   = 1'b1;
          prev_code = code;
        end
        btm_pkg::BTN_LAMP_OFF: begin
          queue_request(btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_FWD, 8'd0,
                        btm_pkg::CMD_M1_FWD, btm_pkg::CMD_M2_FWD, 8'd0,
                        btm_pkg::CMD_M1_FWD, 8'd0);
          lamp_on   = 1'b0;
          prev_code = code;
        end
        default: begin
          // coast: ramp down and repeat the last pattern, previous code kept
          speed = floor_sub(speed, {4'd0, cfg.ramp_step});
          queue_motion(prev_code, speed, {1'b0, cfg.coast_offset});
        end
      endcase
    end
  endfunction

  always @(posedge clk) begin : watch
    frame_rec_t want;
    if (rst) begin
      cfg.ramp_step      = btm_pkg::RST_RAMP_STEP;
      cfg.straight_limit = btm_pkg::RST_STRAIGHT_LIMIT;
      cfg.turn_limit     = btm_pkg::RST_TURN_LIMIT;
      cfg.curve_limit    = btm_pkg::RST_CURVE_LIMIT;
      cfg.conveyor_speed = btm_pkg::RST_CONVEYOR_SPEED;
      cfg.press_offset   = btm_pkg::RST_PRESS_OFFSET;
      cfg.coast_offset   = btm_pkg::RST_COAST_OFFSET;
      speed     = 8'd0;
      prev_code = 8'd0;
      lamp_on   = 1'b0;
      frames_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[btm_pkg::ADDR_W-1:2])
          btm_pkg::REG_RAMP_STEP:      cfg.ramp_step      = pwdata[3:0];
          btm_pkg::REG_STRAIGHT_LIMIT: cfg.straight_limit = pwdata[6:0];
          btm_pkg::REG_TURN_LIMIT:     cfg.turn_limit     = pwdata[6:0];
          btm_pkg::REG_CURVE_LIMIT:    cfg.curve_limit    = pwdata[6:0];
          btm_pkg::REG_CONVEYOR_SPEED: cfg.conveyor_speed = pwdata[6:0];
          btm_pkg::REG_PRESS_OFFSET:   cfg.press_offset   = pwdata[6:0];
          btm_pkg::REG_COAST_OFFSET:   cfg.coast_offset   = pwdata[6:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (frames_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: frame with nothing expected: addr %0d cmd %0d val %0d", $realtime,
                     driver_address, motor_command, drive_value);
        end else begin
          want = frames_due.pop_front();
          frames_checked++;
          if (driver_address !== want.addr || motor_command !== want.cmd ||
              drive_value !== want.val || check_byte !== want.sum7 ||
              lamp_level !== want.lamp || last_frame !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: frame mismatch exp addr %0d cmd %0d val %0d chk %0d lamp %0b ",
                        "last %0b, got addr %0d cmd %0d val %0d chk %0d lamp %0b last %0b"},
                       $realtime, want.addr, want.cmd, want.val, want.sum7, want.lamp,
                       want.last, driver_address, motor_command, drive_value, check_byte,
                       lamp_level, last_frame);
          end
        end
      end
      if (push && !full)
        frames_for_button(button_code);
    end
    frames_waiting = frames_due.size();
  end

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Stimulus and verdict for the button code to motor frame converter.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic [7:0] NOISE_LOW  = 8'h00;
  localparam logic [7:0] NOISE_HIGH = 8'hFF;
  localparam logic [7:0] NOISE_MIX  = 8'hA5;
  localparam logic [7:0] NOISE_ALT  = 8'h7E;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [btm_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       push;
  logic                       full;
  logic [7:0]                 button_code;
  logic                       empty;
  logic                       pop;
  logic [7:0]                 driver_address;
  logic [2:0]                 motor_command;
  logic [6:0]                 drive_value;
  logic [6:0]                 check_byte;
  logic                       lamp_level;
  logic                       last_frame;

  int fail_count;
  int frames_pending;
  int frames_seen;
  int codes_sent;
  int settings_used;
  bit tx_steady;
  bit rx_steady;
  bit hold_rx;

  button_to_motor_frames dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .push(push), .full(full), .button_code(button_code),
    .empty(empty), .pop(pop),
    .driver_address(driver_address), .motor_command(motor_command),
    .drive_value(drive_value), .check_byte(check_byte),
    .lamp_level(lamp_level), .last_frame(last_frame)
  );

  btm_frame_checker frame_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .push(push), .full(full), .button_code(button_code),
    .empty(empty), .pop(pop),
    .driver_address(driver_address), .motor_command(motor_command),
    .drive_value(drive_value), .check_byte(check_byte),
    .lamp_level(lamp_level), .last_frame(last_frame),
    .mismatches(fail_count), .frames_waiting(frames_pending), .frames_checked(frames_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // frame receiver: random pops, a steady stretch, and one long hold
  initial begin : receiver
    int held;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        pop <= 1'b0;
        for (held = 0; held < 300; held++) @(posedge clk);
        hold_rx = 1'b0;
      end else begin
        pop <= rx_steady || ($urandom_range(0, 99) >= 35);
      end
    end
  end

  function automatic logic [7:0] motion_code(input int idx);
    case (idx)
      0:       return btm_pkg::BTN_FORWARD;
      1:       return btm_pkg::BTN_DIAG_R;
      2:       return btm_pkg::BTN_DIAG_L;
      3:       return btm_pkg::BTN_BACKWARD;
      4:       return btm_pkg::BTN_SPIN_A;
      5:       return btm_pkg::BTN_SPIN_B;
      6:       return btm_pkg::BTN_CURVE_A;
      default: return btm_pkg::BTN_CURVE_B;
    endcase
  endfunction

  function automatic logic [7:0] aux_code(input int idx);
    case (idx)
      0:       return btm_pkg::BTN_BELT_REV;
      1:       return btm_pkg::BTN_BELT_FWD;
      2:       return btm_pkg::BTN_LAMP_ON;
      default: return btm_pkg::BTN_LAMP_OFF;
    endcase
  endfunction

  // setup then access phase; the caller lowers psel after the last write
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == btm_pkg::REG_RAMP_STEP) ? 32'h0000_000F : 32'h0000_007F;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (value & mask) | ($urandom() & ~mask);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [3:0] step, input logic [6:0] straight,
                                input logic [6:0] turn, input logic [6:0] curve,
                                input logic [6:0] belt, input logic [6:0] press,
                                input logic [6:0] coast);
    cfg_write(btm_pkg::REG_RAMP_STEP, {28'd0, step});
    cfg_write(btm_pkg::REG_STRAIGHT_LIMIT, {25'd0, straight});
    cfg_write(btm_pkg::REG_TURN_LIMIT, {25'd0, turn});
    cfg_write(btm_pkg::REG_CURVE_LIMIT, {25'd0, curve});
    cfg_write(btm_pkg::REG_CONVEYOR_SPEED, {25'd0, belt});
    cfg_write(btm_pkg::REG_PRESS_OFFSET, {25'd0, press});
    cfg_write(btm_pkg::REG_COAST_OFFSET, {25'd0, coast});
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic apply_random_settings();
    apply_settings(4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)),
                   7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                   7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                   7'($urandom_range(0, 127)));
  endtask

  // push stays high from one request to the next unless an idle gap comes
  task automatic send_code(input logic [7:0] code);
    if (!tx_steady && $urandom_range(0, 99) < 35) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push        <= 1'b1;
    button_code <= code;
    @(posedge clk);
    while (full) @(posedge clk);
    codes_sent++;
  endtask

  // mostly held drive buttons so the speed reaches the ceilings, plus coast runs
  task automatic send_burst();
    int          kind;
    int          reps;
    logic [7:0]  code;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      code = motion_code($urandom_range(0, 7));
      reps = $urandom_range(1, 14);
    end else if (kind < 70) begin
      code = aux_code($urandom_range(0, 3));
      reps = $urandom_range(1, 2);
    end else begin
      code = NOISE_LOW;
      reps = $urandom_range(1, 8);
    end
    repeat (reps) send_code((kind >= 70) ? 8'($urandom_range(0, 255)) : code);
  endtask

  task automatic random_phase(input int count);
    int target;
    target = codes_sent + count;
    while (codes_sent < target) send_burst();
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int wait_cycles;
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    push        = 1'b0;
    button_code = '0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    hold_rx     = 1'b0;
    codes_sent  = 0;
    settings_used = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values; first code idles with no drive pattern stored yet
    send_code(NOISE_LOW);
    send_code(btm_pkg::BTN_FORWARD);
    send_code(btm_pkg::BTN_FORWARD);
    send_code(btm_pkg::BTN_DIAG_R);
    send_code(btm_pkg::BTN_DIAG_L);
    send_code(btm_pkg::BTN_BACKWARD);
    send_code(btm_pkg::BTN_SPIN_A);
    send_code(btm_pkg::BTN_SPIN_B);
    send_code(btm_pkg::BTN_CURVE_A);
    send_code(btm_pkg::BTN_CURVE_B);
    send_code(NOISE_MIX);
    send_code(btm_pkg::BTN_BELT_REV);
    send_code(NOISE_HIGH);
    send_code(btm_pkg::BTN_BELT_FWD);
    send_code(btm_pkg::BTN_LAMP_ON);
    send_code(btm_pkg::BTN_DIAG_R);
    send_code(NOISE_MIX);
    send_code(btm_pkg::BTN_LAMP_OFF);
    send_code(btm_pkg::BTN_DIAG_L);
    send_code(NOISE_ALT);
    send_code(NOISE_HIGH);
    random_phase(45);
    drain();

    apply_settings(4'd15, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127);
    random_phase(40);
    drain();

    // all zero: a high speed gets pulled down to the zero ceiling
    apply_settings(4'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
    random_phase(25);
    drain();

    cfg_write(REG_UNUSED, $urandom());
    apply_random_settings();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    random_phase(40);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    drain();

    // receiver holds off while requests keep coming until push stalls
    apply_random_settings();
    hold_rx   = 1'b1;
    tx_steady = 1'b1;
    random_phase(20);
    tx_steady = 1'b0;
    random_phase(20);
    drain();

    apply_random_settings();
    random_phase(40);
    drain();

    apply_settings(4'd1, 7'd127, 7'd127, 7'd0, 7'd0, 7'd0, 7'd127);
    random_phase(40);

    push <= 1'b0;
    wait_cycles = 0;
    @(posedge clk);
    while (frames_pending != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    $display("run: %0d button codes under %0d register settings, %0d frames checked",
             codes_sent, settings_used, frames_seen);
    $display("run: %0d mismatches, %0d frames never delivered", fail_count, frames_pending);
    if (fail_count == 0 && frames_pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  assign pready = 1'b1;

endmodule
`default_nettype wire

>>> filelist.f
+incdir+sv
sv/btm_pkg.sv
sv/btm_regs.sv
sv/btm_front.sv
sv/btm_queue.sv
sv/btm_back.sv
sv/button_to_motor_frames.sv
tb/sv/btm_frame_checker.sv
tb/sv/testbench.sv
